>>> src/hprs_pkg.sv
`default_nettype none
// ============================================================================
// hprs_pkg
// Shared types and codes for the hazard-pointer retire/scan engine.
// ============================================================================
package hprs_pkg;

    localparam int CMD_W    = 1;
    localparam int THREAD_W = 3;
    localparam int SLOT_W   = 4;
    localparam int THRESH_W = 6;
    localparam int COUNT_W  = 7;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_RETIRE = 1'b0,
        CMD_HAZARD = 1'b1
    } cmd_t;

endpackage : hprs_pkg
`default_nettype wire

>>> src/hazard_pointer_retire_scan.sv
`default_nettype none
// ============================================================================
// hazard_pointer_retire_scan
// Hazard-pointer reclamation engine: per-thread retired stacks and scan.
// ============================================================================
// Usage:
//   Commands are taken when start is high and busy low. A retire that
//   pushes its stack past the threshold scans the n stacked entries
//   twice, each entry by a memory read and then a compare against all
//   hazard slots at once: first to count the kept entries, then to emit
//   the freed ones.
//   busy stays high until the retire or scan has fully finished.
//   Each freed address appears for one cycle with valid; the last of a
//   scan has last_freed set; kept_count is the stack size after the scan.
//   The receiver cannot stall the results. The threshold register is
//   written through cfg_valid/cfg_ready (always ready); the user must
//   write it only while idle, which the block does not enforce.
//   Reset clears all counts, empties the hazard table and sets the
//   threshold to 32; stack contents are not cleared.
// ============================================================================
module hazard_pointer_retire_scan #(
    parameter int THREADS      = 8,
    parameter int HAZARD_SLOTS = 16,
    parameter int STACK_DEPTH  = 64,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [hprs_pkg::CMD_W-1:0]    cmd,
    input  wire logic [hprs_pkg::THREAD_W-1:0] thread,
    input  wire logic [ADDR_BITS-1:0]          node_addr,
    input  wire logic [hprs_pkg::SLOT_W-1:0]   slot,
    input  wire logic [ADDR_BITS-1:0]          hazard_value,
    output logic                               valid,
    output logic [ADDR_BITS-1:0]               freed_addr,
    output logic                               last_freed,
    output logic [hprs_pkg::COUNT_W-1:0]       kept_count,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hprs_pkg::THRESH_W-1:0] cfg_data
);
    import hprs_pkg::*;

    logic [THRESH_W-1:0]               thresh_reg;
    logic [HAZARD_SLOTS*ADDR_BITS-1:0] hazards;
    logic                              q_valid;
    logic [THREAD_W-1:0]               q_thread;
    logic [ADDR_BITS-1:0]              q_addr;
    logic                              q_pop;
    logic                              scan_active;
    logic                              done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= cfg_data;
        end
    end

    hprs_front #(
        .HAZARD_SLOTS (HAZARD_SLOTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .thread       (thread),
        .node_addr    (node_addr),
        .slot         (slot),
        .hazard_value (hazard_value),
        .scan_active  (scan_active),
        .hazards      (hazards),
        .q_valid      (q_valid),
        .q_thread     (q_thread),
        .q_addr       (q_addr),
        .q_pop        (q_pop)
    );

    hprs_back #(
        .THREADS      (THREADS),
        .HAZARD_SLOTS (HAZARD_SLOTS),
        .STACK_DEPTH  (STACK_DEPTH),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold    (thresh_reg),
        .hazards      (hazards),
        .q_valid      (q_valid),
        .q_thread     (q_thread),
        .q_addr       (q_addr),
        .q_pop        (q_pop),
        .scan_active  (scan_active),
        .done         (done),
        .out_valid    (valid),
        .freed_addr   (freed_addr),
        .last_freed   (last_freed),
        .kept_count   (kept_count)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");

endmodule : hazard_pointer_retire_scan
`default_nettype wire

>>> src/hprs_front.sv
`default_nettype none
// ============================================================================
// hprs_front
// Command front end: takes commands, writes the hazard table directly and
// forwards retires to the back end through a two-entry queue.
// ============================================================================
module hprs_front #(
    parameter int HAZARD_SLOTS = 16,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [hprs_pkg::CMD_W-1:0]    cmd,
    input  wire logic [hprs_pkg::THREAD_W-1:0] thread,
    input  wire logic [ADDR_BITS-1:0]          node_addr,
    input  wire logic [hprs_pkg::SLOT_W-1:0]   slot,
    input  wire logic [ADDR_BITS-1:0]          hazard_value,
    input  wire logic                          scan_active,
    output logic [HAZARD_SLOTS*ADDR_BITS-1:0]  hazards,
    output logic                               q_valid,
    output logic [hprs_pkg::THREAD_W-1:0]      q_thread,
    output logic [ADDR_BITS-1:0]               q_addr,
    input  wire logic                          q_pop
);
    import hprs_pkg::*;

    localparam int HW = (HAZARD_SLOTS > 1) ? $clog2(HAZARD_SLOTS) : 1;

    logic [ADDR_BITS-1:0]  haz_reg [HAZARD_SLOTS];
    logic [1:0]            cnt_reg;
    logic [THREAD_W-1:0]   qt_reg [2];
    logic [ADDR_BITS-1:0]  qa_reg [2];
    logic                  accept;
    logic                  push;

    // Hazard writes must not race a scan in flight; queue must have room.
    assign busy   = scan_active || (cnt_reg != 2'd0);
    assign accept = start && !busy;
    assign push   = accept && (cmd_t'(cmd) == CMD_RETIRE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HAZARD_SLOTS; i++)
            begin
                haz_reg[i] <= '0;
            end
        end
        else if (accept && cmd_t'(cmd) == CMD_HAZARD
                 && 32'(slot) < HAZARD_SLOTS)
        begin
            haz_reg[HW'(slot)] <= hazard_value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < HAZARD_SLOTS; i++)
        begin
            hazards[i*ADDR_BITS +: ADDR_BITS] = haz_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            unique case ({push, q_pop && q_valid})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_valid)
        begin
            qt_reg[0] <= qt_reg[1];
            qa_reg[0] <= qa_reg[1];
        end
        if (push)
        begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && q_pop))
            begin
                qt_reg[0] <= thread;
                qa_reg[0] <= node_addr;
            end
            else
            begin
                qt_reg[1] <= thread;
                qa_reg[1] <= node_addr;
            end
        end
    end

    assign q_valid  = cnt_reg != 2'd0;
    assign q_thread = qt_reg[0];
    assign q_addr   = qa_reg[0];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue overflow");
    a_busy_q: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> busy) else $error("accept with queued retire");
    a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid) else $error("push lost");

endmodule : hprs_front
`default_nettype wire

>>> src/hprs_back.sv
`default_nettype none
// ============================================================================
// hprs_back
// Retire engine: pushes onto the per-thread stack and runs the scan, one
// stacked entry at a time, compared against all hazard slots in
// parallel. A first pass counts the kept entries, a second pass emits the
// freed ones and writes the kept ones into the thread's other bank.
// ============================================================================
module hprs_back #(
    parameter int THREADS      = 8,
    parameter int HAZARD_SLOTS = 16,
    parameter int STACK_DEPTH  = 64,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [hprs_pkg::THRESH_W-1:0] threshold,
    input  wire logic [HAZARD_SLOTS*ADDR_BITS-1:0] hazards,
    input  wire logic                          q_valid,
    input  wire logic [hprs_pkg::THREAD_W-1:0] q_thread,
    input  wire logic [ADDR_BITS-1:0]          q_addr,
    output logic                               q_pop,
    output logic                               scan_active,
    output logic                               done,
    output logic                               out_valid,
    output logic [ADDR_BITS-1:0]               freed_addr,
    output logic                               last_freed,
    output logic [hprs_pkg::COUNT_W-1:0]       kept_count
);
    import hprs_pkg::*;

    localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int DW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int MD  = THREADS * STACK_DEPTH;
    localparam int MW  = $clog2(2 * MD);

    typedef enum logic [2:0] {
        S_IDLE, S_PUSH, S_READ, S_CMP, S_FLUSH
    } state_t;

    logic [ADDR_BITS-1:0] mem [2*MD];
    logic [CW-1:0]        cnt_reg [THREADS];
    logic                 bank_reg [THREADS];

    state_t               state_reg;
    logic [TW-1:0]        t_reg;
    logic [CW-1:0]        rd_reg;
    logic [CW-1:0]        kept_reg;
    logic [CW-1:0]        total_reg;
    logic                 pass_reg;
    logic [ADDR_BITS-1:0] rdata_reg;
    logic [ADDR_BITS-1:0] pend_reg;
    logic                 pend_v_reg;
    logic                 done_reg;
    logic                 out_v_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic                 out_last_reg;

    logic                 we;
    logic [MW-1:0]        waddr;
    logic [ADDR_BITS-1:0] wdata;
    logic [MW-1:0]        raddr;
    logic                 hit;
    logic [CW-1:0]        cur_cnt;
    logic                 cur_bank;
    logic [MW-1:0]        cur_base;
    logic [MW-1:0]        alt_base;

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < HAZARD_SLOTS; i++)
        begin
            if (hazards[i*ADDR_BITS +: ADDR_BITS] == rdata_reg)
            begin
                hit = 1'b1;
            end
        end
        if (rdata_reg == '0)
        begin
            hit = 1'b0;
        end
    end

    assign cur_cnt  = cnt_reg[t_reg];
    assign cur_bank = bank_reg[t_reg];
    assign cur_base = MW'(cur_bank) * MW'(MD) + MW'(t_reg) * MW'(STACK_DEPTH);
    assign alt_base = MW'(!cur_bank) * MW'(MD) + MW'(t_reg) * MW'(STACK_DEPTH);
    assign raddr    = cur_base + MW'(rd_reg[DW-1:0]);

    always_comb
    begin
        we    = 1'b0;
        waddr = alt_base + MW'(kept_reg[DW-1:0]);
        wdata = rdata_reg;
        if (state_reg == S_PUSH)
        begin
            we    = cur_cnt < CW'(STACK_DEPTH);
            waddr = cur_base + MW'(cur_cnt[DW-1:0]);
            wdata = pend_reg;
        end
        else if (state_reg == S_CMP)
        begin
            we = hit && pass_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            t_reg        <= '0;
            rd_reg       <= '0;
            kept_reg     <= '0;
            total_reg    <= '0;
            pass_reg     <= 1'b0;
            pend_reg     <= '0;
            pend_v_reg   <= 1'b0;
            done_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            out_addr_reg <= '0;
            out_last_reg <= 1'b0;
            for (int i = 0; i < THREADS; i++)
            begin
                cnt_reg[i]  <= '0;
                bank_reg[i] <= 1'b0;
            end
        end
        else
        begin
            out_v_reg <= 1'b0;
            done_reg  <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (32'(q_thread) < THREADS)
                        begin
                            t_reg     <= TW'(q_thread);
                            pend_reg  <= q_addr;
                            state_reg <= S_PUSH;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                S_PUSH:
                begin
                    logic [CW-1:0] n;
                    n = (cur_cnt < CW'(STACK_DEPTH)) ? cur_cnt + CW'(1) : cur_cnt;
                    cnt_reg[t_reg] <= n;
                    if (CW'(threshold) < n)
                    begin
                        rd_reg     <= n - CW'(1);
                        kept_reg   <= '0;
                        total_reg  <= '0;
                        pass_reg   <= 1'b0;
                        pend_v_reg <= 1'b0;
                        state_reg  <= S_READ;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!pass_reg)
                    begin
                        if (hit)
                        begin
                            total_reg <= total_reg + CW'(1);
                        end
                        if (rd_reg == '0)
                        begin
                            rd_reg   <= cur_cnt - CW'(1);
                            pass_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_reg <= rd_reg - CW'(1);
                        end
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            kept_reg <= kept_reg + CW'(1);
                        end
                        else
                        begin
                            if (pend_v_reg)
                            begin
                                out_v_reg    <= 1'b1;
                                out_addr_reg <= pend_reg;
                                out_last_reg <= 1'b0;
                            end
                            pend_reg   <= rdata_reg;
                            pend_v_reg <= 1'b1;
                        end
                        if (rd_reg == '0)
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            rd_reg    <= rd_reg - CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FLUSH:
                begin
                    cnt_reg[t_reg]  <= kept_reg;
                    bank_reg[t_reg] <= !cur_bank;
                    if (pend_v_reg)
                    begin
                        out_v_reg    <= 1'b1;
                        out_addr_reg <= pend_reg;
                        out_last_reg <= 1'b1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign scan_active = (state_reg != S_IDLE) || out_v_reg || done_reg;
    assign done        = done_reg;
    assign out_valid   = out_v_reg;
    assign freed_addr  = out_addr_reg;
    assign last_freed  = out_v_reg && out_last_reg;
    assign kept_count  = COUNT_W'(total_reg);

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= CW'(STACK_DEPTH)) else $error("kept overflow");
    a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |=> state_reg == S_IDLE) else $error("flush");
    a_cmp_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_READ) else $error("cmp order");

endmodule : hprs_back
`default_nettype wire
